/* rtl/gfmw_pkg.sv */
package gfmw_pkg;

    localparam int GRID_SIDE_DEF   = 64;
    localparam int WINDOW_SIDE_DEF = 8;
    localparam int NUM_FEATURES    = 6;
    localparam int FEAT_W          = 6;
    localparam int COUNT_W         = 13;
    localparam int POS_W           = 24;
    localparam int SHIFT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CHAN_W          = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT = 2'd2;

    localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = 5'd8;

    typedef enum logic [1:0] {
        REQ_OBSERVE = 2'd0,
        REQ_WINDOW  = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_SETUP,
        ST_OBS,
        ST_WIN,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic                    clr;
        logic [NUM_FEATURES-1:0] inc;
    } t_cnt_ctl;

endpackage

/* rtl/gfmw_cell_mem.sv */
module gfmw_cell_mem #(
    parameter int DEPTH = gfmw_pkg::GRID_SIDE_DEF * gfmw_pkg::GRID_SIDE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [gfmw_pkg::FEAT_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [gfmw_pkg::FEAT_W-1:0] o_rdata
);

    logic [gfmw_pkg::FEAT_W-1:0] r_mem [DEPTH];
    logic [gfmw_pkg::FEAT_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* rtl/gfmw_counts.sv */
module gfmw_counts (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gfmw_pkg::t_cnt_ctl           i_ctl,
    input  logic [gfmw_pkg::CHAN_W-1:0]  i_chan,
    output logic [gfmw_pkg::COUNT_W-1:0] o_visited,
    output logic [gfmw_pkg::COUNT_W-1:0] o_selected
);

    logic [gfmw_pkg::COUNT_W-1:0] r_cnt [gfmw_pkg::NUM_FEATURES];
    logic [gfmw_pkg::COUNT_W-1:0] n_cnt [gfmw_pkg::NUM_FEATURES];

    // Counts wrap at the field width, so only the low bits are kept.
    always_comb begin
        for (int f = 0; f < gfmw_pkg::NUM_FEATURES; f++) begin
            if (i_ctl.clr) begin
                n_cnt[f] = '0;
            end else begin
                n_cnt[f] = r_cnt[f] + gfmw_pkg::COUNT_W'(i_ctl.inc[f]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < gfmw_pkg::NUM_FEATURES; f++) begin
            if (!i_rst_n) begin
                r_cnt[f] <= '0;
            end else begin
                r_cnt[f] <= n_cnt[f];
            end
        end
    end

    // Report the post-update values so a beat reflects its own marking.
    always_comb begin
        o_visited  = n_cnt[0];
        o_selected = '0;
        for (int f = 0; f < gfmw_pkg::NUM_FEATURES; f++) begin
            if (i_chan == gfmw_pkg::CHAN_W'(f)) begin
                o_selected = n_cnt[f];
            end
        end
    end

endmodule

/* rtl/grid_feature_map_window.sv */
// Occupancy grid of GRID_SIDE x GRID_SIDE cells, six sticky feature bits each.
// Input channel (i_in_valid / o_in_ready) takes one request per beat:
// observe marks one cell, window read streams WINDOW_SIDE^2 cells in row
// order, clear wipes the grid. Output channel (o_out_valid / i_out_ready)
// delivers one beat per result; o_last flags the final beat of a request.
// Configuration writes (i_cfg_we) set origin and cell shift; the user must
// make them only while idle, as the block itself does not enforce it.
// An observe or window read passes through the MAP and SETUP states before
// OBS or WIN registers its first result; the unused request type goes from
// MAP to REPLY. A window read streams one cell per cycle off the single
// memory read port while the receiver is ready; a clear writes one cell
// per cycle. After reset the block sweeps all GRID_SIDE^2 memory cells to
// zero (4096 at the default size) and holds o_in_ready low meanwhile.
// A stalled receiver holds the output register; the window stream pauses
// and resumes without losing or repeating a cell. A new request is taken
// while the final result of the previous one still waits in the output.
module grid_feature_map_window #(
    parameter int GRID_SIDE   = gfmw_pkg::GRID_SIDE_DEF,
    parameter int WINDOW_SIDE = gfmw_pkg::WINDOW_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gfmw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gfmw_pkg::POS_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_req_type,
    input  logic signed [gfmw_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [gfmw_pkg::POS_W-1:0] i_pos_y,
    input  logic                             i_saw_water,
    input  logic                             i_saw_food,
    input  logic                             i_saw_resource,
    input  logic                             i_saw_danger,
    input  logic                             i_saw_building,
    input  logic [gfmw_pkg::CHAN_W-1:0]      i_count_channel,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gfmw_pkg::FEAT_W-1:0]      o_cell_features,
    output logic                             o_in_grid,
    output logic                             o_last,
    output logic [gfmw_pkg::COUNT_W-1:0]     o_visited_count,
    output logic [gfmw_pkg::COUNT_W-1:0]     o_selected_count
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(GRID_SIDE);
    localparam int WCW   = $clog2(WINDOW_SIDE);
    localparam int HALF  = WINDOW_SIDE / 2;
    localparam int DW    = gfmw_pkg::POS_W + 1;
    localparam int CW    = gfmw_pkg::POS_W + 2;
    localparam int FW    = gfmw_pkg::FEAT_W;

    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [WCW-1:0] LAST_IDX  = WCW'(WINDOW_SIDE - 1);

    function automatic logic [AW-1:0] f_addr(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        return AW'(y[IW-1:0]) * AW'(GRID_SIDE) + AW'(x[IW-1:0]);
    endfunction

    function automatic logic f_on_grid(logic signed [CW-1:0] v);
        return !v[CW-1] && (v[CW-2:0] < (CW-1)'(GRID_SIDE));
    endfunction

    // Configuration
    logic signed [gfmw_pkg::POS_W-1:0] r_org_x, r_org_y;
    logic [gfmw_pkg::SHIFT_W-1:0]      r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_shift <= gfmw_pkg::CELL_SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gfmw_pkg::CFG_ORIGIN_X:   r_org_x <= i_cfg_data;
                gfmw_pkg::CFG_ORIGIN_Y:   r_org_y <= i_cfg_data;
                gfmw_pkg::CFG_CELL_SHIFT: r_shift <= i_cfg_data[gfmw_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and datapath registers
    gfmw_pkg::t_state r_state, n_state;
    gfmw_pkg::t_req   r_req;
    logic signed [gfmw_pkg::POS_W-1:0] r_pos_x, r_pos_y;
    logic [FW-1:0]                     r_mark;
    logic [gfmw_pkg::CHAN_W-1:0]       r_chan;
    logic signed [DW-1:0]              r_gx, r_gy, n_gx, n_gy;
    logic signed [CW-1:0]              r_x, r_y, r_x0, n_x, n_y, n_x0;
    logic [WCW-1:0]                    r_col, r_row, n_col, n_row;
    logic [AW-1:0]                     r_addr, n_addr;
    logic [AW-1:0]                     r_clr, n_clr;
    logic                              r_reply, n_reply;

    logic                              r_out_valid, n_out_valid;
    logic [FW-1:0]                     r_out_feat, n_out_feat;
    logic                              r_out_in, n_out_in;
    logic                              r_out_last, n_out_last;
    logic [gfmw_pkg::COUNT_W-1:0]      r_out_vis, n_out_vis;
    logic [gfmw_pkg::COUNT_W-1:0]      r_out_sel, n_out_sel;

    // Memory and counter interface
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [FW-1:0]          mem_wdata;
    logic [FW-1:0]          mem_q;
    gfmw_pkg::t_cnt_ctl     cnt_ctl;
    logic [gfmw_pkg::COUNT_W-1:0] cnt_vis, cnt_sel;

    logic                   in_acc;
    logic                   out_free;
    logic                   cur_on;
    logic signed [DW-1:0]   d_x, d_y;
    logic [FW-1:0]          fresh;

    assign o_in_ready = (r_state == gfmw_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign cur_on     = f_on_grid(r_x) && f_on_grid(r_y);
    assign d_x        = DW'(r_pos_x) - DW'(r_org_x);
    assign d_y        = DW'(r_pos_y) - DW'(r_org_y);
    assign fresh      = r_mark & ~mem_q;

    gfmw_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_addr),
        .o_rdata (mem_q)
    );

    gfmw_counts u_counts (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cnt_ctl),
        .i_chan     (r_chan),
        .o_visited  (cnt_vis),
        .o_selected (cnt_sel)
    );

    always_comb begin
        n_state     = r_state;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_x         = r_x;
        n_y         = r_y;
        n_x0        = r_x0;
        n_col       = r_col;
        n_row       = r_row;
        n_addr      = r_addr;
        n_clr       = r_clr;
        n_reply     = r_reply;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_feat  = r_out_feat;
        n_out_in    = r_out_in;
        n_out_last  = r_out_last;
        n_out_vis   = r_out_vis;
        n_out_sel   = r_out_sel;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        cnt_ctl     = '0;

        unique case (r_state)
            gfmw_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = r_reply ? gfmw_pkg::ST_REPLY : gfmw_pkg::ST_IDLE;
                end
            end
            gfmw_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = gfmw_pkg::ST_MAP;
                end
            end
            gfmw_pkg::ST_MAP: begin
                // floor to the cell: arithmetic shift of the offset from origin
                n_gx = d_x >>> r_shift;
                n_gy = d_y >>> r_shift;
                unique case (r_req)
                    gfmw_pkg::REQ_OBSERVE,
                    gfmw_pkg::REQ_WINDOW: n_state = gfmw_pkg::ST_SETUP;
                    gfmw_pkg::REQ_CLEAR: begin
                        cnt_ctl.clr = 1'b1;
                        n_clr       = '0;
                        n_reply     = 1'b1;
                        n_state     = gfmw_pkg::ST_CLEAR;
                    end
                    default: n_state = gfmw_pkg::ST_REPLY;
                endcase
            end
            gfmw_pkg::ST_SETUP: begin
                n_col = '0;
                n_row = '0;
                if (r_req == gfmw_pkg::REQ_WINDOW) begin
                    n_x     = CW'(r_gx) - CW'(HALF);
                    n_y     = CW'(r_gy) - CW'(HALF);
                    n_state = gfmw_pkg::ST_WIN;
                end else begin
                    n_x     = CW'(r_gx);
                    n_y     = CW'(r_gy);
                    n_state = gfmw_pkg::ST_OBS;
                end
                n_x0   = n_x;
                n_addr = f_addr(n_x, n_y);
            end
            gfmw_pkg::ST_OBS: begin
                if (out_free) begin
                    if (cur_on) begin
                        mem_we      = 1'b1;
                        mem_wdata   = mem_q | r_mark;
                        cnt_ctl.inc = fresh;
                    end
                    n_out_valid = 1'b1;
                    n_out_feat  = cur_on ? (mem_q | r_mark) : '0;
                    n_out_in    = cur_on;
                    n_out_last  = 1'b1;
                    n_out_vis   = cnt_vis;
                    n_out_sel   = cnt_sel;
                    n_state     = gfmw_pkg::ST_IDLE;
                end
            end
            gfmw_pkg::ST_WIN: begin
                // hold the address while stalled so the read data stays current
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_feat  = cur_on ? mem_q : '0;
                    n_out_in    = cur_on;
                    n_out_last  = (r_col == LAST_IDX) && (r_row == LAST_IDX);
                    n_out_vis   = cnt_vis;
                    n_out_sel   = cnt_sel;
                    if (n_out_last) begin
                        n_state = gfmw_pkg::ST_IDLE;
                    end else if (r_col == LAST_IDX) begin
                        n_col  = '0;
                        n_row  = r_row + WCW'(1);
                        n_x    = r_x0;
                        n_y    = r_y + CW'(1);
                        n_addr = f_addr(n_x, n_y);
                    end else begin
                        n_col  = r_col + WCW'(1);
                        n_x    = r_x + CW'(1);
                        n_addr = f_addr(n_x, n_y);
                    end
                end
            end
            gfmw_pkg::ST_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_feat  = '0;
                    n_out_in    = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_vis   = cnt_vis;
                    n_out_sel   = cnt_sel;
                    n_reply     = 1'b0;
                    n_state     = gfmw_pkg::ST_IDLE;
                end
            end
            default: n_state = gfmw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfmw_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_reply     <= n_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req   <= gfmw_pkg::t_req'(i_req_type);
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_mark  <= {i_saw_building, i_saw_danger, i_saw_resource,
                        i_saw_food, i_saw_water, 1'b1};
            r_chan  <= i_count_channel;
        end
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_x        <= n_x;
        r_y        <= n_y;
        r_x0       <= n_x0;
        r_col      <= n_col;
        r_row      <= n_row;
        r_addr     <= n_addr;
        r_out_feat <= n_out_feat;
        r_out_in   <= n_out_in;
        r_out_last <= n_out_last;
        r_out_vis  <= n_out_vis;
        r_out_sel  <= n_out_sel;
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_features  = r_out_feat;
    assign o_in_grid        = r_out_in;
    assign o_last           = r_out_last;
    assign o_visited_count  = r_out_vis;
    assign o_selected_count = r_out_sel;

endmodule
